// ----- hdl/oewn_pkg.sv -----
// Shared types, constants and helper functions for the one-edit word neighbour check.
`default_nettype none

package oewn_pkg;

  localparam int MAX_LEN   = 8;
  localparam int CHAR_W    = 8;
  localparam int CHARS_W   = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 2;

  typedef logic [MAX_LEN-1:0][CHAR_W-1:0] word_t;
  typedef logic [LEN_W-1:0]               len_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANGE_ENABLE = 2'd0,
    REG_SWAP_ENABLE   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic change_enable;
    logic swap_enable;
  } cfg_t;

  // Saturate a length at the longest word held.
  function automatic len_t clamp_len(input len_t len);
    clamp_len = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
  endfunction

  // Unpack characters, zeroing positions at or beyond the length.
  function automatic word_t mask_word(input logic [CHARS_W-1:0] chars, input len_t len);
    word_t w;
    for (int k = 0; k < MAX_LEN; k++) begin
      w[k] = (LEN_W'(k) < len) ? chars[k*CHAR_W +: CHAR_W] : '0;
    end
    mask_word = w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/oewn_cfg_regs.sv -----
// Mode configuration registers written over the configuration channel.
`default_nettype none

module oewn_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [oewn_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic                           wr_data,
  output oewn_pkg::cfg_t                      cfg
);

  logic change_enable;
  logic swap_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_enable <= 1'b1;
      swap_enable   <= 1'b0;
    end else if (wr_en) begin
      unique case (oewn_pkg::cfg_reg_t'(wr_index))
        oewn_pkg::REG_CHANGE_ENABLE: change_enable <= wr_data;
        oewn_pkg::REG_SWAP_ENABLE:   swap_enable   <= wr_data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg.change_enable = change_enable;
  assign cfg.swap_enable   = swap_enable;

endmodule

`default_nettype wire

// ----- hdl/oewn_compare.sv -----
// Position-parallel comparison of two masked words under the one-edit rules.
`default_nettype none

module oewn_compare (
  input  wire oewn_pkg::word_t word_a,
  input  wire oewn_pkg::len_t  len_a,
  input  wire oewn_pkg::word_t word_b,
  input  wire oewn_pkg::len_t  len_b,
  input  wire oewn_pkg::cfg_t  cfg,
  output logic                 ok
);

  localparam int N = oewn_pkg::MAX_LEN;

  logic [N-1:0]    diff;
  logic [N-1:0]    first_diff;
  logic [N-1:0]    swap_hit;
  logic [N-1:0]    eq_pass;
  logic            eq_ok;
  oewn_pkg::word_t long_w;
  oewn_pkg::word_t short_w;
  logic [N-1:0]    step_diff;
  logic [N-1:0]    skip_diff;
  logic [N-1:0]    step_first;
  logic [N-1:0]    step_pass;
  logic            step_ok;
  logic            same_len;
  logic            a_longer;
  logic            b_longer;

  // Equal lengths: one change, or one adjacent swap, after the first mismatch.
  always_comb begin
    logic below;
    logic above1;
    logic above2;
    logic use_swap;
    for (int k = 0; k < N; k++) begin
      diff[k] = word_a[k] != word_b[k];
    end
    for (int k = 0; k < N; k++) begin
      below  = 1'b0;
      above1 = 1'b0;
      above2 = 1'b0;
      for (int m = 0; m < N; m++) begin
        if (m < k)     below  = below  | diff[m];
        if (m > k)     above1 = above1 | diff[m];
        if (m > k + 1) above2 = above2 | diff[m];
      end
      first_diff[k] = diff[k] & ~below;
      if (k + 1 < N) begin
        swap_hit[k] = (word_a[k] == word_b[(k + 1) % N]) &&
                      (word_a[(k + 1) % N] == word_b[k]);
      end else begin
        swap_hit[k] = 1'b0;
      end
      use_swap   = cfg.swap_enable & swap_hit[k];
      eq_pass[k] = first_diff[k] &
                   ((use_swap & ~above2) | (~use_swap & cfg.change_enable & ~above1));
    end
    eq_ok = ~(|diff) | (|eq_pass);
  end

  // Lengths one apart: one character dropped from the longer word.
  always_comb begin
    logic below;
    logic skip_above;
    logic [oewn_pkg::CHAR_W-1:0] next_c;
    long_w  = (len_a > len_b) ? word_a : word_b;
    short_w = (len_a > len_b) ? word_b : word_a;
    for (int k = 0; k < N; k++) begin
      next_c       = (k + 1 < N) ? long_w[(k + 1) % N] : '0;
      step_diff[k] = long_w[k] != short_w[k];
      skip_diff[k] = next_c != short_w[k];
    end
    for (int k = 0; k < N; k++) begin
      below      = 1'b0;
      skip_above = 1'b0;
      for (int m = 0; m < N; m++) begin
        if (m < k)  below      = below | step_diff[m];
        if (m >= k) skip_above = skip_above | skip_diff[m];
      end
      step_first[k] = step_diff[k] & ~below;
      step_pass[k]  = step_first[k] & ~skip_above;
    end
    step_ok = ~(|step_diff) | (|step_pass);
  end

  assign same_len = len_a == len_b;
  assign a_longer = len_a == oewn_pkg::LEN_W'(len_b + 1'b1);
  assign b_longer = len_b == oewn_pkg::LEN_W'(len_a + 1'b1);

  always_comb begin
    priority if (same_len) begin
      ok = (cfg.change_enable | cfg.swap_enable) & eq_ok;
    end else if (a_longer || b_longer) begin
      ok = step_ok;
    end else begin
      ok = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/one_edit_word_neighbor_check.sv -----
// Top level: request register, comparison logic and result register.
//
// Use: a request carries two words (first_chars/first_length and
// second_chars/second_length, up to eight byte characters each) and is taken
// at a rising edge with in_valid high and in_stall low. Each request gives one
// result, is_neighbor, taken at an edge with out_valid high and out_stall low.
// The request register is loaded at the accepting edge and the result register
// when that request advances, which out_stall can hold off. Throughput is one
// request per cycle while out_stall is low; the comparison over all
// character positions is a single combinational stage between the two
// registers. While out_stall is high the result holds, the request register
// keeps the next request, and in_stall rises once that register is occupied.
// Mode registers (change_enable, swap_enable) are written through cfg_valid,
// cfg_ready (always high), cfg_index and cfg_data, by the user only while no
// request is in flight; the block does not enforce this. Synchronous reset
// empties both registers and sets change_enable to 1 and swap_enable to 0.
`default_nettype none

module one_edit_word_neighbor_check (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [oewn_pkg::CHARS_W-1:0]          first_chars,
  input  wire logic [oewn_pkg::LEN_W-1:0]            first_length,
  input  wire logic [oewn_pkg::CHARS_W-1:0]          second_chars,
  input  wire logic [oewn_pkg::LEN_W-1:0]            second_length,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       is_neighbor,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [oewn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic                                  cfg_data
);

  oewn_pkg::cfg_t  cfg;
  logic            req_valid;
  oewn_pkg::word_t req_a;
  oewn_pkg::word_t req_b;
  oewn_pkg::len_t  req_len_a;
  oewn_pkg::len_t  req_len_b;
  logic            advance;
  logic            in_take;
  logic            ok;

  assign cfg_ready = 1'b1;

  oewn_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Result register can load when empty or being drained this cycle.
  assign advance  = req_valid & (~out_valid | ~out_stall);
  assign in_stall = req_valid & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_take) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_len_a <= oewn_pkg::clamp_len(first_length);
      req_len_b <= oewn_pkg::clamp_len(second_length);
      req_a     <= oewn_pkg::mask_word(first_chars, oewn_pkg::clamp_len(first_length));
      req_b     <= oewn_pkg::mask_word(second_chars, oewn_pkg::clamp_len(second_length));
    end
  end

  oewn_compare u_compare (
    .word_a (req_a),
    .len_a  (req_len_a),
    .word_b (req_b),
    .len_b  (req_len_b),
    .cfg    (cfg),
    .ok     (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_neighbor <= ok;
    end
  end

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !req_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid && out_valid && out_stall)
    else $error("input stalled without a blocked request");

  a_far_lengths_fail: assert property (@(posedge clk) disable iff (rst)
    advance && (req_len_a > oewn_pkg::LEN_W'(req_len_b + 1'b1) ||
                req_len_b > oewn_pkg::LEN_W'(req_len_a + 1'b1)) |=> !is_neighbor)
    else $error("lengths more than one apart reported as neighbours");

  a_no_mode_equal_fails: assert property (@(posedge clk) disable iff (rst)
    advance && req_len_a == req_len_b && !cfg.change_enable && !cfg.swap_enable
    |=> !is_neighbor)
    else $error("equal lengths passed with no mode enabled");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the one-edit word neighbour check: directed table plus random pairs.
module testbench;

  localparam int LIMIT         = 200000;
  localparam int NUM_DIRECTED  = 24;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 212;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 4;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [oewn_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [oewn_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // Mode settings per random phase, phase 0 in bit 0.
  localparam bit [RANDOM_PHASES-1:0] PHASE_CHANGE = 8'b10110101;
  localparam bit [RANDOM_PHASES-1:0] PHASE_SWAP   = 8'b11100110;

  typedef logic [9:0][oewn_pkg::CHAR_W-1:0] padded_t;
  typedef enum logic [1:0] {WANT_NO, WANT_YES, WANT_MODEL} want_t;

  typedef struct packed {
    bit                           change_en;
    bit                           swap_en;
    logic [oewn_pkg::CHARS_W-1:0] a;
    oewn_pkg::len_t               la;
    logic [oewn_pkg::CHARS_W-1:0] b;
    oewn_pkg::len_t               lb;
    want_t                        want;
  } plan_row_t;

  typedef struct packed {
    logic [oewn_pkg::CHARS_W-1:0] a;
    oewn_pkg::len_t               la;
    logic [oewn_pkg::CHARS_W-1:0] b;
    oewn_pkg::len_t               lb;
    bit                           verdict;
  } verdict_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [oewn_pkg::CHARS_W-1:0]   first_chars = '0;
  oewn_pkg::len_t                 first_length = '0;
  logic [oewn_pkg::CHARS_W-1:0]   second_chars = '0;
  oewn_pkg::len_t                 second_length = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           is_neighbor;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [oewn_pkg::CFG_IDX_W-1:0] cfg_index = oewn_pkg::REG_CHANGE_ENABLE;
  logic                           cfg_data = 1'b0;

  bit       mode_change = 1'b1;
  bit       mode_swap = 1'b0;
  bit       steady = 1'b0;
  verdict_t pending_verdicts[$];
  int       rcv_hold = 0;
  int       stall_mark = 0;
  int       cycles = 0;
  int       mismatches = 0;
  int       requests_sent = 0;
  int       results_seen = 0;
  int       neighbours_seen = 0;
  int       mode_writes = 0;

  plan_row_t plan [NUM_DIRECTED] = '{
    '{1'b1, 1'b0, 64'h746163, 4'd3, 64'h746163, 4'd3, WANT_YES},
    '{1'b1, 1'b0, 64'h746163, 4'd3, 64'h746f63, 4'd3, WANT_YES},
    '{1'b1, 1'b0, 64'h746163, 4'd3, 64'h746361, 4'd3, WANT_NO},
    '{1'b1, 1'b0, 64'h746163, 4'd3, 64'h73746163, 4'd4, WANT_YES},
    '{1'b1, 1'b0, 64'h746163, 4'd3, 64'h6163, 4'd2, WANT_YES},
    '{1'b1, 1'b0, 64'h746163, 4'd3, 64'h63, 4'd1, WANT_NO},
    '{1'b1, 1'b0, {oewn_pkg::CHARS_W{1'b1}}, 4'd8, {oewn_pkg::CHARS_W{1'b1}}, 4'd8, WANT_YES},
    '{1'b1, 1'b0, {oewn_pkg::CHARS_W{1'b1}}, 4'd15, {oewn_pkg::CHARS_W{1'b1}}, 4'd8, WANT_YES},
    '{1'b1, 1'b0, 64'h0, 4'd0, 64'h0, 4'd0, WANT_YES},
    '{1'b1, 1'b0, 64'h0, 4'd0, 64'h41, 4'd1, WANT_YES},
    '{1'b1, 1'b0, 64'hdeadbeef00746163, 4'd3, 64'h746163, 4'd3, WANT_YES},
    '{1'b1, 1'b0, 64'h0, 4'd0, 64'h6162, 4'd2, WANT_NO},
    '{1'b1, 1'b0, {oewn_pkg::CHARS_W{1'b1}}, 4'd9, 64'h00ffffffffffffff, 4'd7, WANT_MODEL},
    '{1'b1, 1'b0, {oewn_pkg::CHARS_W{1'b1}}, 4'd8, 64'h0, 4'd8, WANT_NO},
    '{1'b0, 1'b1, 64'h746163, 4'd3, 64'h746361, 4'd3, WANT_YES},
    '{1'b0, 1'b1, 64'h746163, 4'd3, 64'h746f63, 4'd3, WANT_NO},
    '{1'b0, 1'b1, 64'h64636261, 4'd4, 64'h63646162, 4'd4, WANT_NO},
    '{1'b0, 1'b1, 64'h746163, 4'd3, 64'h73746163, 4'd4, WANT_YES},
    '{1'b0, 1'b0, 64'h746163, 4'd3, 64'h746163, 4'd3, WANT_NO},
    '{1'b0, 1'b0, 64'h0, 4'd0, 64'h0, 4'd0, WANT_NO},
    '{1'b0, 1'b0, 64'h746163, 4'd3, 64'h73746163, 4'd4, WANT_YES},
    '{1'b1, 1'b1, 64'h746163, 4'd3, 64'h746361, 4'd3, WANT_YES},
    '{1'b1, 1'b1, 64'h746163, 4'd3, 64'h746f63, 4'd3, WANT_YES},
    '{1'b1, 1'b1, 64'h64636261, 4'd4, 64'h65636162, 4'd4, WANT_MODEL}
  };

  one_edit_word_neighbor_check u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_chars   (first_chars),
    .first_length  (first_length),
    .second_chars  (second_chars),
    .second_length (second_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_neighbor   (is_neighbor),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Longer word against shorter one: allow at most one skipped character.
  function automatic bit one_insert_ok(input padded_t lw, input int ll, input padded_t sw);
    int i;
    int j;
    bit skipped;
    bit ok;
    i = 0;
    j = 0;
    skipped = 1'b0;
    ok = 1'b1;
    while (ok && i < ll) begin
      if (lw[i] != sw[j]) begin
        if (skipped || lw[i+1] != sw[j]) begin
          ok = 1'b0;
        end else begin
          skipped = 1'b1;
          i++;
        end
      end
      i++;
      j++;
    end
    return ok;
  endfunction

  function automatic bit predict_neighbor(input logic [oewn_pkg::CHARS_W-1:0] a,
                                          input oewn_pkg::len_t la_raw,
                                          input logic [oewn_pkg::CHARS_W-1:0] b,
                                          input oewn_pkg::len_t lb_raw);
    padded_t pa;
    padded_t pb;
    int      la;
    int      lb;
    int      i;
    bit      ok;
    bit      edited;
    la = (la_raw > oewn_pkg::MAX_LEN) ? oewn_pkg::MAX_LEN : int'(la_raw);
    lb = (lb_raw > oewn_pkg::MAX_LEN) ? oewn_pkg::MAX_LEN : int'(lb_raw);
    pa = '0;
    pb = '0;
    // Positions at or past the length read as zero.
    for (i = 0; i < oewn_pkg::MAX_LEN; i++) begin
      if (i < la) pa[i] = a[oewn_pkg::CHAR_W*i +: oewn_pkg::CHAR_W];
      if (i < lb) pb[i] = b[oewn_pkg::CHAR_W*i +: oewn_pkg::CHAR_W];
    end
    if (la == lb) begin
      ok = mode_change || mode_swap;
      edited = 1'b0;
      i = 0;
      while (ok && i < la) begin
        if (pa[i] != pb[i]) begin
          if (edited) begin
            ok = 1'b0;
          end else begin
            edited = 1'b1;
            if (mode_swap && i + 1 < la && pa[i] == pb[i+1] && pa[i+1] == pb[i]) i++;
            else if (!mode_change) ok = 1'b0;
          end
        end
        i++;
      end
    end else if (la == lb + 1) begin
      ok = one_insert_ok(pa, la, pb);
    end else if (lb == la + 1) begin
      ok = one_insert_ok(pb, lb, pa);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // Drop valid and wait until every request has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [oewn_pkg::CFG_IDX_W-1:0] idx, input bit val);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      oewn_pkg::REG_CHANGE_ENABLE: mode_change = val;
      oewn_pkg::REG_SWAP_ENABLE:   mode_swap = val;
      default: ;
    endcase
    mode_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input logic [oewn_pkg::CHARS_W-1:0] a,
                              input oewn_pkg::len_t la,
                              input logic [oewn_pkg::CHARS_W-1:0] b,
                              input oewn_pkg::len_t lb, input want_t want);
    verdict_t e;
    int       gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    first_chars <= a;
    first_length <= la;
    second_chars <= b;
    second_length <= lb;
    do @(posedge clk); while (in_stall);
    e.a = a;
    e.la = la;
    e.b = b;
    e.lb = lb;
    e.verdict = (want == WANT_MODEL) ? predict_neighbor(a, la, b, lb) : (want == WANT_YES);
    pending_verdicts.insert(pending_verdicts.size(), e);
    requests_sent++;
  endtask

  // Mostly a word and a lightly edited copy; some pure noise.
  task automatic make_pair(output logic [oewn_pkg::CHARS_W-1:0] a, output oewn_pkg::len_t la,
                           output logic [oewn_pkg::CHARS_W-1:0] b, output oewn_pkg::len_t lb);
    logic [oewn_pkg::CHAR_W-1:0]  w [0:8];
    logic [oewn_pkg::CHAR_W-1:0]  v [0:8];
    logic [oewn_pkg::CHARS_W-1:0] tmp_chars;
    oewn_pkg::len_t               tmp_len;
    int                           n;
    int                           m;
    int                           p;
    int                           k;
    bit                           tiny;
    if ($urandom_range(0, 9) == 0) begin
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      la = oewn_pkg::len_t'($urandom_range(0, 15));
      lb = oewn_pkg::len_t'($urandom_range(0, 15));
    end else begin
      n = $urandom_range(1, oewn_pkg::MAX_LEN);
      tiny = $urandom_range(0, 1);
      for (k = 0; k < 9; k++) begin
        if (k >= n) w[k] = '0;
        else if (tiny) w[k] = 8'h61 + 8'($urandom_range(0, 3));
        else w[k] = 8'($urandom);
        v[k] = w[k];
      end
      m = n;
      case ($urandom_range(0, 7))
        1: begin
          p = $urandom_range(0, n - 1);
          v[p] = w[p] ^ 8'($urandom_range(1, 255));
        end
        2: if (n > 1) begin
          p = $urandom_range(0, n - 2);
          v[p] = w[p+1];
          v[p+1] = w[p];
        end
        3: begin
          p = $urandom_range(0, n);
          for (k = 8; k > p; k--) v[k] = w[k-1];
          v[p] = tiny ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom);
          m = n + 1;
        end
        4: begin
          p = $urandom_range(0, n - 1);
          for (k = p; k < 8; k++) v[k] = w[k+1];
          v[8] = '0;
          m = n - 1;
        end
        5: begin
          p = $urandom_range(0, n - 1);
          v[p] = v[p] ^ 8'($urandom_range(1, 255));
          p = $urandom_range(0, n - 1);
          v[p] = v[p] ^ 8'($urandom_range(1, 255));
        end
        6: begin
          if (n > 1) begin
            p = $urandom_range(0, n - 2);
            v[p] = w[p+1];
            v[p+1] = w[p];
          end
          p = $urandom_range(0, n - 1);
          v[p] = v[p] ^ 8'($urandom_range(1, 255));
        end
        7: begin
          m = $urandom_range(1, oewn_pkg::MAX_LEN);
          for (k = 0; k < 9; k++) v[k] = (k < m) ? 8'($urandom) : '0;
        end
        default: ;
      endcase
      a = '0;
      b = '0;
      for (k = 0; k < oewn_pkg::MAX_LEN; k++) begin
        a[oewn_pkg::CHAR_W*k +: oewn_pkg::CHAR_W] = w[k];
        b[oewn_pkg::CHAR_W*k +: oewn_pkg::CHAR_W] = v[k];
      end
      // Junk past the length must be masked by the block.
      if ($urandom_range(0, 4) == 0)
        for (k = n; k < oewn_pkg::MAX_LEN; k++)
          a[oewn_pkg::CHAR_W*k +: oewn_pkg::CHAR_W] = 8'($urandom);
      if ($urandom_range(0, 4) == 0)
        for (k = m; k < oewn_pkg::MAX_LEN; k++)
          b[oewn_pkg::CHAR_W*k +: oewn_pkg::CHAR_W] = 8'($urandom);
      la = oewn_pkg::len_t'(n);
      lb = oewn_pkg::len_t'(m);
    end
    if ($urandom_range(0, 1)) begin
      tmp_chars = a;
      a = b;
      b = tmp_chars;
      tmp_len = la;
      la = lb;
      lb = tmp_len;
    end
  endtask

  // Draw a fresh hold after every accepted result, then count it down.
  always @(negedge clk) begin
    if (results_seen != stall_mark) begin
      stall_mark = results_seen;
      rcv_hold = steady ? 0 : $urandom_range(0, 3);
    end
    if (rcv_hold != 0) begin
      out_stall <= 1'b1;
      rcv_hold = rcv_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_result
    verdict_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result is_neighbor=%0b at cycle %0d", is_neighbor, cycles);
      end else begin
        e = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (is_neighbor !== e.verdict) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: %h/%0d vs %h/%0d expected %0b got %0b",
                     e.a, e.la, e.b, e.lb, e.verdict, is_neighbor);
        end
        if (is_neighbor === 1'b1) neighbours_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timed out with %0d requests outstanding", pending_verdicts.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [oewn_pkg::CHARS_W-1:0] a;
    logic [oewn_pkg::CHARS_W-1:0] b;
    oewn_pkg::len_t               la;
    oewn_pkg::len_t               lb;
    int                           r;
    int                           ph;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Spare indexes first: the directed rows below show the modes untouched.
    write_mode(REG_SPARE_LO, 1'b0);
    write_mode(REG_SPARE_HI, 1'b1);
    for (r = 0; r < NUM_DIRECTED; r++) begin
      if (plan[r].change_en != mode_change)
        write_mode(oewn_pkg::REG_CHANGE_ENABLE, plan[r].change_en);
      if (plan[r].swap_en != mode_swap)
        write_mode(oewn_pkg::REG_SWAP_ENABLE, plan[r].swap_en);
      send_request(plan[r].a, plan[r].la, plan[r].b, plan[r].lb, plan[r].want);
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_mode(oewn_pkg::REG_CHANGE_ENABLE, PHASE_CHANGE[ph]);
      write_mode(oewn_pkg::REG_SWAP_ENABLE, PHASE_SWAP[ph]);
      if (ph == 4) write_mode(REG_SPARE_HI, !mode_swap);
      steady = (ph == 2 || ph == 5);
      repeat (PHASE_ITEMS) begin
        make_pair(a, la, b, lb);
        send_request(a, la, b, lb, WANT_MODEL);
      end
    end
    settle();

    $display("Covered %0d requests and %0d results (%0d neighbours) over %0d mode writes,",
             requests_sent, results_seen, neighbours_seen, mode_writes);
    $display("all four mode settings, with and without idle cycles; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
